// ===== rtl/core/adll_pkg.sv =====
// ----------------------------------------------------------------------------
// adll_pkg
// Shared types, codes and field widths of the array-backed doubly linked list.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package adll_pkg;

  // Default pool geometry.
  localparam int SLOTS_DEF       = 16;
  localparam int RECORD_BITS_DEF = 32;

  // Field widths of the stream words.
  localparam int CMD_W      = 3;
  localparam int ANCHOR_W   = 5;
  localparam int ENTRY_W    = 32;
  localparam int STATUS_W   = 2;
  localparam int SLOT_W     = 4;
  localparam int REC_OUT_W  = 32;
  localparam int COUNT_W    = 5;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_PAD_W  = OUT_DATA_W - SLOT_W - REC_OUT_W - COUNT_W;

  // Command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_ADD_FIRST = 3'd0,
    CMD_ADD_AFTER = 3'd1,
    CMD_ADD_LAST  = 3'd2,
    CMD_DEL_FIRST = 3'd3,
    CMD_DEL_AFTER = 3'd4,
    CMD_DEL_LAST  = 3'd5,
    CMD_WALK_FWD  = 3'd6,
    CMD_WALK_REV  = 3'd7
  } cmd_t;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STAT_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL       = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY      = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_BAD_ANCHOR = 2'd3;

  // Operation on the slot map.
  typedef struct packed {
    logic alloc;
    logic retire;
  } slot_op_t;

  // Write enables of the two link banks.
  typedef struct packed {
    logic fwd;
    logic bwd;
  } link_we_t;

endpackage

`default_nettype wire

// ===== rtl/core/array_doubly_linked_list.sv =====
// ----------------------------------------------------------------------------
// array_doubly_linked_list
// Doubly linked list over a fixed slot pool, kept in a link memory and a
// record memory, driven by a command sequencer with one output register.
// ----------------------------------------------------------------------------
// Each command is accepted in the idle state, and its result word is registered
//   from its last state: an add via link and fix, a del_after via find and link;
//   a traversal then gives 1 word per cycle while the output register is free.
//   A new command is taken only in the idle state, once the free-slot scan after
//   a stored add has finished; a stalled output holds every state that emits.
// Reset: synchronous; list empty, every slot free; memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module array_doubly_linked_list
  import adll_pkg::*;
#(
  parameter int SLOTS       = SLOTS_DEF,
  parameter int RECORD_BITS = RECORD_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Input words: command [2:0], anchor_slot [7:3], entry_data [39:8].
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // Result words: slot [3:0], record_out [35:4], entry_count [40:36], zero above.
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [OUT_DATA_W-1:0] out_tdata,
  // Result kind: status [1:0].
  output logic      [STATUS_W-1:0]   out_tuser,
  output logic                       out_tlast
);

  localparam int IW = $clog2(SLOTS);
  localparam int LW = IW + 1;
  localparam logic [LW-1:0] NIL      = {1'b1, {IW{1'b0}}};
  localparam logic [LW-1:0] LAST_K   = LW'(SLOTS - 1);

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_ADD_LINK = 6'b000010,
    ST_ADD_FIX  = 6'b000100,
    ST_DEL_FIND = 6'b001000,
    ST_DEL_LINK = 6'b010000,
    ST_WALK     = 6'b100000
  } state_t;

  state_t                 state_r,   state_nxt;
  cmd_t                   cmd_r,     cmd_nxt;
  logic                   anc_ok_r,  anc_ok_nxt;
  logic [ENTRY_W-1:0]     entry_r,   entry_nxt;
  logic [IW-1:0]          addr_r,    addr_nxt;
  logic [LW-1:0]          p_r,       p_nxt;
  logic [LW-1:0]          n_r,       n_nxt;
  logic [LW-1:0]          s_r,       s_nxt;
  logic [LW-1:0]          k_r,       k_nxt;
  logic [LW-1:0]          head_r,    head_nxt;
  logic [LW-1:0]          tail_r,    tail_nxt;
  logic [LW-1:0]          count_r,   count_nxt;

  logic                   out_valid_r;
  logic [OUT_DATA_W-1:0]  out_data_r;
  logic [STATUS_W-1:0]    out_user_r;
  logic                   out_last_r;

  // Input word fields.
  cmd_t                   in_cmd;
  logic [ANCHOR_W-1:0]    in_anchor;
  logic [ENTRY_W-1:0]     in_entry;
  logic [IW-1:0]          anchor_idx;
  logic                   anchor_in_range;
  logic                   accept;
  logic                   out_free;

  // Memory and slot map connections.
  link_we_t               link_we;
  logic [IW-1:0]          fwd_waddr, bwd_waddr;
  logic [LW-1:0]          fwd_wdata, bwd_wdata;
  logic [LW-1:0]          rd_fwd, rd_bwd;
  logic                   rec_we;
  logic [RECORD_BITS-1:0] rec_rd;
  slot_op_t               slot_op;
  logic [IW-1:0]          slot_idx;
  logic                   q_occ;
  logic [LW-1:0]          free_ptr;
  logic                   scan_busy;

  // Emitted result.
  logic                   emit;
  logic [STATUS_W-1:0]    e_status;
  logic [LW-1:0]          e_slot;
  logic [REC_OUT_W-1:0]   e_rec;
  logic                   e_last;
  logic [LW-1:0]          walk_next;

  assign in_cmd          = cmd_t'(in_tdata[CMD_W-1:0]);
  assign in_anchor       = in_tdata[CMD_W+ANCHOR_W-1:CMD_W];
  assign in_entry        = in_tdata[IN_DATA_W-1:CMD_W+ANCHOR_W];
  assign anchor_idx      = IW'(in_anchor[ANCHOR_W-2:0]);
  assign anchor_in_range = !in_anchor[ANCHOR_W-1] &&
                           (32'(in_anchor[ANCHOR_W-2:0]) < SLOTS);

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && !scan_busy;
  assign accept    = in_tvalid && in_tready;
  assign walk_next = (cmd_r == CMD_WALK_FWD) ? rd_fwd : rd_bwd;

  // Command sequencer. The read address of the memories is always addr_nxt,
  // so read data in a state belongs to addr_r. Writes finish before the next
  // read issued from the idle state, so no access overlaps another.
  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    anc_ok_nxt = anc_ok_r;
    entry_nxt  = entry_r;
    addr_nxt   = addr_r;
    p_nxt      = p_r;
    n_nxt      = n_r;
    s_nxt      = s_r;
    k_nxt      = k_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    link_we    = '0;
    fwd_waddr  = s_r[IW-1:0];
    fwd_wdata  = n_r;
    bwd_waddr  = s_r[IW-1:0];
    bwd_wdata  = p_r;
    rec_we     = 1'b0;
    slot_op    = '0;
    slot_idx   = s_r[IW-1:0];
    emit       = 1'b0;
    e_status   = STAT_OK;
    e_slot     = '0;
    e_rec      = '0;
    e_last     = 1'b1;

    case (state_r)
      ST_IDLE: begin
        case (in_cmd)
          CMD_DEL_FIRST, CMD_WALK_FWD: addr_nxt = head_r[IW-1:0];
          CMD_DEL_LAST, CMD_WALK_REV:  addr_nxt = tail_r[IW-1:0];
          default:                     addr_nxt = anchor_idx;
        endcase
        if (accept) begin
          cmd_nxt    = in_cmd;
          anc_ok_nxt = anchor_in_range && q_occ;
          entry_nxt  = in_entry;
          k_nxt      = '0;
          s_nxt      = (in_cmd == CMD_DEL_LAST || in_cmd == CMD_WALK_REV) ? tail_r : head_r;
          case (in_cmd)
            CMD_ADD_FIRST, CMD_ADD_AFTER, CMD_ADD_LAST: state_nxt = ST_ADD_LINK;
            CMD_DEL_FIRST, CMD_DEL_LAST:                state_nxt = ST_DEL_LINK;
            CMD_DEL_AFTER:                              state_nxt = ST_DEL_FIND;
            default:                                    state_nxt = ST_WALK;
          endcase
        end
      end

      // Check the anchor and room, then write the new slot's own links.
      ST_ADD_LINK: begin
        if (out_free) begin
          if (cmd_r == CMD_ADD_AFTER && !anc_ok_r) begin
            emit      = 1'b1;
            e_status  = STAT_BAD_ANCHOR;
            state_nxt = ST_IDLE;
          end else if (free_ptr[IW]) begin
            emit      = 1'b1;
            e_status  = STAT_FULL;
            state_nxt = ST_IDLE;
          end else begin
            case (cmd_r)
              CMD_ADD_FIRST: begin
                p_nxt = NIL;
                n_nxt = head_r;
              end
              CMD_ADD_LAST: begin
                p_nxt = tail_r;
                n_nxt = NIL;
              end
              default: begin
                p_nxt = {1'b0, addr_r};
                n_nxt = rd_fwd;
              end
            endcase
            s_nxt         = free_ptr;
            link_we.fwd   = 1'b1;
            link_we.bwd   = 1'b1;
            fwd_waddr     = free_ptr[IW-1:0];
            fwd_wdata     = n_nxt;
            bwd_waddr     = free_ptr[IW-1:0];
            bwd_wdata     = p_nxt;
            rec_we        = 1'b1;
            slot_op.alloc = 1'b1;
            slot_idx      = free_ptr[IW-1:0];
            state_nxt     = ST_ADD_FIX;
          end
        end
      end

      // Point the neighbors (or head and tail) at the new slot.
      ST_ADD_FIX: begin
        if (out_free) begin
          if (p_r[IW]) begin
            head_nxt = s_r;
          end else begin
            link_we.fwd = 1'b1;
            fwd_waddr   = p_r[IW-1:0];
            fwd_wdata   = s_r;
          end
          if (n_r[IW]) begin
            tail_nxt = s_r;
          end else begin
            link_we.bwd = 1'b1;
            bwd_waddr   = n_r[IW-1:0];
            bwd_wdata   = s_r;
          end
          count_nxt = count_r + LW'(1);
          emit      = 1'b1;
          e_slot    = s_r;
          state_nxt = ST_IDLE;
        end
      end

      // The anchor's forward link names the slot to remove.
      ST_DEL_FIND: begin
        if (out_free) begin
          if (!anc_ok_r || rd_fwd[IW]) begin
            emit      = 1'b1;
            e_status  = STAT_BAD_ANCHOR;
            state_nxt = ST_IDLE;
          end else begin
            s_nxt     = rd_fwd;
            addr_nxt  = rd_fwd[IW-1:0];
            state_nxt = ST_DEL_LINK;
          end
        end
      end

      // Splice the slot out between its two neighbors.
      ST_DEL_LINK: begin
        if (out_free) begin
          if (s_r[IW]) begin
            emit      = 1'b1;
            e_status  = STAT_EMPTY;
            state_nxt = ST_IDLE;
          end else begin
            if (rd_bwd[IW]) begin
              head_nxt = rd_fwd;
            end else begin
              link_we.fwd = 1'b1;
              fwd_waddr   = rd_bwd[IW-1:0];
              fwd_wdata   = rd_fwd;
            end
            if (rd_fwd[IW]) begin
              tail_nxt = rd_bwd;
            end else begin
              link_we.bwd = 1'b1;
              bwd_waddr   = rd_fwd[IW-1:0];
              bwd_wdata   = rd_bwd;
            end
            slot_op.retire = 1'b1;
            count_nxt      = count_r - LW'(1);
            emit           = 1'b1;
            e_slot         = s_r;
            state_nxt      = ST_IDLE;
          end
        end
      end

      // One entry per cycle; the read address advances only when a word leaves.
      ST_WALK: begin
        if (out_free) begin
          if (s_r[IW]) begin
            emit      = 1'b1;
            e_status  = STAT_EMPTY;
            state_nxt = ST_IDLE;
          end else begin
            emit   = 1'b1;
            e_slot = s_r;
            e_rec  = REC_OUT_W'(rec_rd);
            e_last = walk_next[IW] || (k_r == LAST_K);
            if (e_last) begin
              state_nxt = ST_IDLE;
            end else begin
              s_nxt    = walk_next;
              addr_nxt = walk_next[IW-1:0];
              k_nxt    = k_r + LW'(1);
            end
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= NIL;
      tail_r      <= NIL;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= emit || (out_valid_r && !out_tready);
    end
  end

  // Item and walk payload registers.
  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    anc_ok_r <= anc_ok_nxt;
    entry_r  <= entry_nxt;
    addr_r   <= addr_nxt;
    p_r      <= p_nxt;
    n_r      <= n_nxt;
    s_r      <= s_nxt;
    k_r      <= k_nxt;
  end

  // Output register; loaded only when empty or being drained.
  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= {{OUT_PAD_W{1'b0}}, COUNT_W'(count_nxt), e_rec,
                     SLOT_W'(e_slot[IW-1:0])};
      out_user_r <= e_status;
      out_last_r <= e_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  adll_link_mem #(
    .SLOTS(SLOTS)
  ) u_link_mem (
    .clk       (clk),
    .we        (link_we),
    .fwd_waddr (fwd_waddr),
    .fwd_wdata (fwd_wdata),
    .bwd_waddr (bwd_waddr),
    .bwd_wdata (bwd_wdata),
    .rd_addr   (addr_nxt),
    .rd_fwd    (rd_fwd),
    .rd_bwd    (rd_bwd)
  );

  adll_rec_mem #(
    .SLOTS       (SLOTS),
    .RECORD_BITS (RECORD_BITS)
  ) u_rec_mem (
    .clk     (clk),
    .we      (rec_we),
    .waddr   (free_ptr[IW-1:0]),
    .wdata   (RECORD_BITS'(entry_r)),
    .rd_addr (addr_nxt),
    .rd_data (rec_rd)
  );

  adll_slot_map #(
    .SLOTS(SLOTS)
  ) u_slot_map (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (slot_op),
    .op_idx   (slot_idx),
    .q_idx    (anchor_idx),
    .q_occ    (q_occ),
    .free_ptr (free_ptr),
    .busy     (scan_busy)
  );

  // The entry count never exceeds the pool.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= LW'(SLOTS))
    else $error("entry count beyond pool size");

  // An empty list has a null head, and only then.
  a_head_count: assert property (@(posedge clk) disable iff (!rst_n)
    head_r[IW] == (count_r == '0))
    else $error("head and entry count disagree");

  // Head and tail are null together.
  a_head_tail: assert property (@(posedge clk) disable iff (!rst_n)
    head_r[IW] == tail_r[IW])
    else $error("head and tail disagree on emptiness");

endmodule

`default_nettype wire

// ===== rtl/core/adll_link_mem.sv =====
// ----------------------------------------------------------------------------
// adll_link_mem
// Link memory: a forward bank and a backward bank, each with its own write
// port, read at one shared address with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module adll_link_mem
  import adll_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF,
  localparam int IW = $clog2(SLOTS),
  localparam int LW = IW + 1
) (
  input  wire logic          clk,
  input  wire link_we_t      we,
  input  wire logic [IW-1:0] fwd_waddr,
  input  wire logic [LW-1:0] fwd_wdata,
  input  wire logic [IW-1:0] bwd_waddr,
  input  wire logic [LW-1:0] bwd_wdata,
  input  wire logic [IW-1:0] rd_addr,
  output logic      [LW-1:0] rd_fwd,
  output logic      [LW-1:0] rd_bwd
);

  logic [LW-1:0] fwd_mem [SLOTS];
  logic [LW-1:0] bwd_mem [SLOTS];

  // Forward bank.
  always_ff @(posedge clk) begin
    if (we.fwd) begin
      fwd_mem[fwd_waddr] <= fwd_wdata;
    end
    rd_fwd <= fwd_mem[rd_addr];
  end

  // Backward bank.
  always_ff @(posedge clk) begin
    if (we.bwd) begin
      bwd_mem[bwd_waddr] <= bwd_wdata;
    end
    rd_bwd <= bwd_mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/adll_rec_mem.sv =====
// ----------------------------------------------------------------------------
// adll_rec_mem
// Record memory: one record word per slot, one write port and one read port
// with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module adll_rec_mem
  import adll_pkg::*;
#(
  parameter int SLOTS       = SLOTS_DEF,
  parameter int RECORD_BITS = RECORD_BITS_DEF,
  localparam int IW = $clog2(SLOTS)
) (
  input  wire logic                   clk,
  input  wire logic                   we,
  input  wire logic [IW-1:0]          waddr,
  input  wire logic [RECORD_BITS-1:0] wdata,
  input  wire logic [IW-1:0]          rd_addr,
  output logic      [RECORD_BITS-1:0] rd_data
);

  logic [RECORD_BITS-1:0] rec_mem [SLOTS];

  // Single write port, registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      rec_mem[waddr] <= wdata;
    end
    rd_data <= rec_mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/adll_slot_map.sv =====
// ----------------------------------------------------------------------------
// adll_slot_map
// Occupancy marks and the lowest-free-slot pointer. After an allocation the
// pointer is rebuilt by a scan that checks one slot per cycle upward.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module adll_slot_map
  import adll_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF,
  localparam int IW = $clog2(SLOTS),
  localparam int LW = IW + 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire slot_op_t      op,
  input  wire logic [IW-1:0] op_idx,
  input  wire logic [IW-1:0] q_idx,
  output logic               q_occ,
  output logic      [LW-1:0] free_ptr,
  output logic               busy
);

  localparam logic [LW-1:0] NIL      = {1'b1, {IW{1'b0}}};
  localparam logic [LW-1:0] SLOTS_LW = LW'(SLOTS);

  logic [SLOTS-1:0] occ_r,  occ_nxt;
  logic [LW-1:0]    free_r, free_nxt;
  logic [LW-1:0]    scan_r, scan_nxt;
  logic             busy_r, busy_nxt;

  assign q_occ    = occ_r[q_idx];
  assign free_ptr = free_r;
  assign busy     = busy_r;

  // Allocation, release and the upward scan for the next free slot.
  always_comb begin
    occ_nxt  = occ_r;
    free_nxt = free_r;
    scan_nxt = scan_r;
    busy_nxt = busy_r;
    if (busy_r) begin
      if (scan_r == SLOTS_LW) begin
        free_nxt = NIL;
        busy_nxt = 1'b0;
      end else if (!occ_r[scan_r[IW-1:0]]) begin
        free_nxt = scan_r;
        busy_nxt = 1'b0;
      end else begin
        scan_nxt = scan_r + LW'(1);
      end
    end
    if (op.alloc) begin
      occ_nxt[op_idx] = 1'b1;
      scan_nxt        = {1'b0, op_idx} + LW'(1);
      busy_nxt        = 1'b1;
    end
    if (op.retire) begin
      occ_nxt[op_idx] = 1'b0;
      if ({1'b0, op_idx} < free_r) begin
        free_nxt = {1'b0, op_idx};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r  <= '0;
      free_r <= '0;
      scan_r <= '0;
      busy_r <= 1'b0;
    end else begin
      occ_r  <= occ_nxt;
      free_r <= free_nxt;
      scan_r <= scan_nxt;
      busy_r <= busy_nxt;
    end
  end

  // An idle free pointer always names a free slot.
  a_free_is_free: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy_r && !free_r[IW]) |-> !occ_r[free_r[IW-1:0]])
    else $error("free pointer names an occupied slot");

endmodule

`default_nettype wire
